@@ rtl/ssrc_pkg.sv @@
`timescale 1ns / 1ps

package ssrc_pkg;

   // Field widths of the channels and registers
   localparam int ACTION_W     = 1;
   localparam int SPEED_W      = 21;
   localparam int POS_W        = 32;
   localparam int STEP_W       = 9;
   localparam int SPEED_CAP_W  = 12;
   localparam int ACCEL_W      = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   // Fixed-point formats
   localparam int Q8_SHIFT     = 8;     // speed is Q8 steps per second
   localparam int FRAC_W       = 16;    // step remainder is Q16 steps
   localparam int STOP_SHIFT   = 17;    // speed^2 / (2 * accel) in Q8 -> whole steps

   // Limits
   localparam int SPEED_LIMIT  = 1048575;
   localparam int STEP_LIMIT   = 255;
   localparam int MS_PER_S     = 1000;

   // Reset values of the registers and default update interval
   localparam int SPEED_CAP_RESET         = 100;
   localparam int ACCEL_RATE_RESET        = 10;
   localparam int UPDATE_INTERVAL_DEFAULT = 60;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_CAP  = 1'b0,
      CSR_ACCEL_RATE = 1'b1
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACTION_SPEED    = 1'b0,
      ACTION_POSITION = 1'b1
   } action_type;

endpackage

@@ rtl/stepper_speed_ramp_controller.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  req      | req_valid / req_stall      | req_action, req_target_speed, req_target_position
//  rsp      | rsp_valid / rsp_stall      | rsp_step_count, rsp_speed_now, rsp_position_now
//  csr      | csr_write_enable           | csr_index, csr_write_data
//
//  Speed command: S_CLAMP, S_UPDATE, S_QLOAD, S_DIV_Q, S_STEP; position command runs
//  S_SQUARE, S_DIV_STOP, S_STOP_CMP in place of S_CLAMP. QW, STOP_W: quotient widths of
//  step amount and stopping distance, one bit per cycle. Reset (synchronous) and each
//  accel_rate write recompute the increment on the same divider, with req_stall high.
//  A finished item waits in the output register under rsp_stall; the next is taken and
//  worked on meanwhile up to its last step.
// ---------------------------------------------------------------------------

module stepper_speed_ramp_controller #(
   parameter int UPDATE_INTERVAL_MS = ssrc_pkg::UPDATE_INTERVAL_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ssrc_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [ssrc_pkg::SPEED_W-1:0]    req_target_speed,
   input  logic signed [ssrc_pkg::POS_W-1:0]      req_target_position,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ssrc_pkg::STEP_W-1:0]     rsp_step_count,
   output logic signed [ssrc_pkg::SPEED_W-1:0]    rsp_speed_now,
   output logic signed [ssrc_pkg::POS_W-1:0]      rsp_position_now,

   input  logic                                   csr_write_enable,
   input  logic [ssrc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ssrc_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   import ssrc_pkg::*;

   // Derived sizes
   localparam int SCALE     = (1 << Q8_SHIFT) * UPDATE_INTERVAL_MS;
   localparam int SCALE_W   = $clog2(SCALE + 1);
   localparam int MAG_W     = SPEED_W - 1;
   localparam longint INC_MAX  = (longint'(1 << ACCEL_W) - 1) * SCALE / MS_PER_S;
   localparam int INC_W     = $clog2(INC_MAX + 1);
   localparam longint INCP_MAX = INC_MAX * UPDATE_INTERVAL_MS;
   localparam int INCP_W    = $clog2(INCP_MAX + 1);
   localparam longint Q_MAX    = longint'(SPEED_LIMIT) * SCALE / MS_PER_S;
   localparam int QW        = $clog2(Q_MAX + 1);
   localparam int STOP_W    = 2 * MAG_W - STOP_SHIFT;
   localparam int DW        = (INC_W > QW) ? ((INC_W > STOP_W) ? INC_W : STOP_W)
                                           : ((QW > STOP_W) ? QW : STOP_W);
   localparam int CNT_W     = $clog2(DW + 1);
   localparam int DIVISOR_W = (ACCEL_W > $clog2(MS_PER_S + 1)) ? ACCEL_W
                                                              : $clog2(MS_PER_S + 1);
   localparam int SUM_W     = ((INC_W > MAG_W) ? INC_W : MAG_W) + 2;
   localparam int AD_W      = POS_W + 1;
   localparam int CMP_W     = (AD_W + Q8_SHIFT > INCP_W) ? AD_W + Q8_SHIFT : INCP_W;
   localparam int STOPP_W   = POS_W + 2;
   localparam int REM_W     = FRAC_W + 1;
   localparam int REST_W    = FRAC_W + 2;
   localparam int WM_W      = QW - FRAC_W;
   localparam int TOT_W     = (WM_W + 2 > STEP_W + 1) ? WM_W + 2 : STEP_W + 1;
   localparam int INC_DVD_W = ACCEL_W + SCALE_W;
   localparam int Q_DVD_W   = MAG_W + SCALE_W;

   localparam logic signed [SUM_W-1:0]  SPD_HI    = SUM_W'(SPEED_LIMIT);
   localparam logic signed [SUM_W-1:0]  SPD_LO    = -SPD_HI;
   localparam logic signed [TOT_W-1:0]  STEP_HI   = TOT_W'(STEP_LIMIT);
   localparam logic signed [TOT_W-1:0]  STEP_LO   = -STEP_HI;
   localparam logic signed [REST_W-1:0] FRAC_ONE  = REST_W'(1 << FRAC_W);
   localparam logic signed [REM_W-1:0]  REM_MIN   = -REM_W'(1 << FRAC_W);

   typedef enum logic [3:0] {
      S_INC_LOAD,
      S_DIV_INC,
      S_INCP,
      S_IDLE,
      S_CLAMP,
      S_SQUARE,
      S_DIV_STOP,
      S_STOP_CMP,
      S_UPDATE,
      S_QLOAD,
      S_DIV_Q,
      S_STEP
   } state_type;

   state_type                  state_ff, state_in;

   // Control and model state
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SPEED_CAP_W-1:0]     speed_cap_ff, speed_cap_in;
   logic [ACCEL_W-1:0]         accel_ff, accel_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [POS_W-1:0]    position_ff, position_in;
   logic signed [REM_W-1:0]    remainder_ff, remainder_in;

   // Payload registers
   logic signed [STEP_W-1:0]   rsp_step_count_ff, rsp_step_count_in;
   logic signed [SPEED_W-1:0]  rsp_speed_now_ff, rsp_speed_now_in;
   logic signed [POS_W-1:0]    rsp_position_now_ff, rsp_position_now_in;
   logic [INC_W-1:0]           inc_ff, inc_in;
   logic [INCP_W-1:0]          inc_p_ff, inc_p_in;
   logic [ACTION_W-1:0]        action_ff, action_in;
   logic signed [SPEED_W-1:0]  tgt_speed_ff, tgt_speed_in;
   logic signed [POS_W-1:0]    tgt_pos_ff, tgt_pos_in;
   logic [AD_W-1:0]            ad_ff, ad_in;
   logic                       slow_ff, slow_in;
   logic                       stop_eq_ff, stop_eq_in;
   logic                       stop_lt_ff, stop_lt_in;
   logic                       snap_ff, snap_in;

   // Bit-serial divider
   logic [DIVISOR_W-1:0]       rem_ff, rem_in;
   logic [DW-1:0]              dq_ff, dq_in;
   logic [DIVISOR_W-1:0]       divisor_ff, divisor_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   // -----------------------------------------------------------------------
   // Divider step: shift one dividend bit into the partial remainder
   logic [DIVISOR_W:0]         div_shifted;
   logic [DIVISOR_W:0]         div_trial;
   logic                       div_fits;
   logic [DIVISOR_W-1:0]       div_rem_step;
   logic [DW-1:0]              div_dq_step;

   always_comb begin
      div_shifted  = {rem_ff, dq_ff[DW-1]};
      div_trial    = div_shifted - {1'b0, divisor_ff};
      div_fits     = div_shifted >= {1'b0, divisor_ff};
      div_rem_step = div_fits ? div_trial[DIVISOR_W-1:0] : div_shifted[DIVISOR_W-1:0];
      div_dq_step  = {dq_ff[DW-2:0], div_fits};
   end

   // -----------------------------------------------------------------------
   // Magnitude of the speed and the products that feed the divider
   logic                       speed_neg;
   logic signed [SPEED_W-1:0]  speed_abs;
   logic [MAG_W-1:0]           mag;
   logic [2*MAG_W-1:0]         sq;
   logic [INC_DVD_W-1:0]       inc_dividend;
   logic [Q_DVD_W-1:0]         q_dividend;

   always_comb begin
      speed_neg    = speed_ff[SPEED_W-1];
      speed_abs    = speed_neg ? -speed_ff : speed_ff;
      mag          = speed_abs[MAG_W-1:0];
      sq           = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
      inc_dividend = INC_DVD_W'(accel_ff) * INC_DVD_W'(SCALE);
      q_dividend   = Q_DVD_W'(mag) * Q_DVD_W'(SCALE);
   end

   // -----------------------------------------------------------------------
   // Distance to the goal and stopping position
   logic signed [POS_W:0]      diff;
   logic signed [STOPP_W-1:0]  pos_x, tgt_x, dist_x, stop_pos;
   logic [CMP_W-1:0]           ad_scaled;

   always_comb begin
      diff      = (POS_W+1)'(tgt_pos_ff) - (POS_W+1)'(position_ff);
      pos_x     = STOPP_W'(position_ff);
      tgt_x     = STOPP_W'(tgt_pos_ff);
      dist_x    = STOPP_W'(dq_ff[STOP_W-1:0]);
      stop_pos  = speed_neg ? pos_x - dist_x : pos_x + dist_x;
      ad_scaled = CMP_W'({ad_ff, {Q8_SHIFT{1'b0}}});
   end

   // -----------------------------------------------------------------------
   // Speed update for both command kinds, then saturation
   logic signed [SUM_W-1:0]    spd_x, inc_x, tspd_x, spd_up, spd_dn, spd_nxt, spd_sat;
   logic signed [SPEED_W-1:0]  speed_lim;

   always_comb begin
      spd_x     = SUM_W'(speed_ff);
      inc_x     = SUM_W'(inc_ff);
      tspd_x    = SUM_W'(tgt_speed_ff);
      spd_up    = spd_x + inc_x;
      spd_dn    = spd_x - inc_x;
      speed_lim = SPEED_W'({speed_cap_ff, {Q8_SHIFT{1'b0}}});
      if (action_ff == ACTION_SPEED) begin
         if (spd_x < tspd_x) begin
            spd_nxt = (spd_up > tspd_x) ? tspd_x : spd_up;
         end else if (spd_x > tspd_x) begin
            spd_nxt = (spd_dn < tspd_x) ? tspd_x : spd_dn;
         end else begin
            spd_nxt = spd_x;
         end
      end else begin
         if (stop_eq_ff) begin
            spd_nxt = spd_x;
         end else if (snap_ff) begin
            spd_nxt = '0;
         end else if (stop_lt_ff) begin
            spd_nxt = spd_up;
         end else begin
            spd_nxt = spd_dn;
         end
      end
      if (spd_nxt > SPD_HI) begin
         spd_sat = SPD_HI;
      end else if (spd_nxt < SPD_LO) begin
         spd_sat = SPD_LO;
      end else begin
         spd_sat = spd_nxt;
      end
   end

   // -----------------------------------------------------------------------
   // Whole steps and remainder carry from the quotient
   logic [WM_W-1:0]            whole_mag;
   logic [FRAC_W-1:0]          frac_mag;
   logic signed [WM_W:0]       whole_s;
   logic signed [FRAC_W:0]     frac_s;
   logic signed [REST_W-1:0]   rest, rest_adj;
   logic signed [1:0]          carry;
   logic signed [TOT_W-1:0]    total;
   logic signed [STEP_W-1:0]   steps;

   always_comb begin
      whole_mag = dq_ff[QW-1:FRAC_W];
      frac_mag  = dq_ff[FRAC_W-1:0];
      whole_s   = speed_neg ? -(WM_W+1)'(whole_mag) : (WM_W+1)'(whole_mag);
      frac_s    = speed_neg ? -(FRAC_W+1)'(frac_mag) : (FRAC_W+1)'(frac_mag);
      rest      = REST_W'(remainder_ff) + REST_W'(frac_s);
      if (rest >= FRAC_ONE) begin
         carry    = 2'sd1;
         rest_adj = rest - FRAC_ONE;
      end else if (rest <= -FRAC_ONE) begin
         carry    = -2'sd1;
         rest_adj = rest + FRAC_ONE;
      end else begin
         carry    = 2'sd0;
         rest_adj = rest;
      end
      total = TOT_W'(whole_s) + TOT_W'(carry);
      if (total > STEP_HI) begin
         steps = STEP_W'(STEP_HI);
      end else if (total < STEP_LO) begin
         steps = STEP_W'(STEP_LO);
      end else begin
         steps = total[STEP_W-1:0];
      end
   end

   // -----------------------------------------------------------------------
   // Sequencer: next values of all registers
   always_comb begin
      state_in            = state_ff;
      rsp_valid_in        = rsp_valid_ff;
      speed_cap_in        = speed_cap_ff;
      accel_in            = accel_ff;
      speed_in            = speed_ff;
      position_in         = position_ff;
      remainder_in        = remainder_ff;
      rsp_step_count_in   = rsp_step_count_ff;
      rsp_speed_now_in    = rsp_speed_now_ff;
      rsp_position_now_in = rsp_position_now_ff;
      inc_in              = inc_ff;
      inc_p_in            = inc_p_ff;
      action_in           = action_ff;
      tgt_speed_in        = tgt_speed_ff;
      tgt_pos_in          = tgt_pos_ff;
      ad_in               = ad_ff;
      slow_in             = slow_ff;
      stop_eq_in          = stop_eq_ff;
      stop_lt_in          = stop_lt_ff;
      snap_in             = snap_ff;
      rem_in              = rem_ff;
      dq_in               = dq_ff;
      divisor_in          = divisor_ff;
      cnt_in              = cnt_ff;

      // output register empties when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // increment = accel * 256 * interval / 1000
         S_INC_LOAD: begin
            rem_in     = DIVISOR_W'(inc_dividend >> INC_W);
            dq_in      = DW'(inc_dividend[INC_W-1:0]) << (DW - INC_W);
            divisor_in = DIVISOR_W'(MS_PER_S);
            cnt_in     = CNT_W'(INC_W);
            state_in   = S_DIV_INC;
         end
         S_DIV_INC: begin
            rem_in = div_rem_step;
            dq_in  = div_dq_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               inc_in   = div_dq_step[INC_W-1:0];
               state_in = S_INCP;
            end
         end
         S_INCP: begin
            inc_p_in = INCP_W'(inc_ff) * INCP_W'(UPDATE_INTERVAL_MS);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               action_in    = req_action;
               tgt_speed_in = req_target_speed;
               tgt_pos_in   = req_target_position;
               state_in     = (req_action == ACTION_POSITION) ? S_SQUARE : S_CLAMP;
            end
         end
         // speed command: clamp the target to +-speed cap
         S_CLAMP: begin
            if (tgt_speed_ff > speed_lim) begin
               tgt_speed_in = speed_lim;
            end else if (tgt_speed_ff < -speed_lim) begin
               tgt_speed_in = -speed_lim;
            end
            state_in = S_UPDATE;
         end
         // position command: load speed^2 / 2^17 for division by accel (by 1 if accel is zero)
         S_SQUARE: begin
            ad_in      = diff[POS_W] ? AD_W'(-diff) : AD_W'(diff);
            slow_in    = (INC_W+MAG_W)'(mag) < (INC_W+MAG_W)'(inc_ff);
            rem_in     = '0;
            dq_in      = DW'(sq[2*MAG_W-1:STOP_SHIFT]) << (DW - STOP_W);
            divisor_in = (accel_ff == '0) ? DIVISOR_W'(1) : DIVISOR_W'(accel_ff);
            cnt_in     = CNT_W'(STOP_W);
            state_in   = S_DIV_STOP;
         end
         S_DIV_STOP: begin
            rem_in = div_rem_step;
            dq_in  = div_dq_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_STOP_CMP;
            end
         end
         S_STOP_CMP: begin
            stop_eq_in = stop_pos == tgt_x;
            stop_lt_in = stop_pos < tgt_x;
            snap_in    = slow_ff && (ad_scaled < CMP_W'(inc_p_ff));
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            speed_in = SPEED_W'(spd_sat);
            state_in = S_QLOAD;
         end
         // step amount = |speed| * interval * 256 / 1000 in Q16
         S_QLOAD: begin
            rem_in     = DIVISOR_W'(q_dividend >> QW);
            dq_in      = DW'(q_dividend[QW-1:0]) << (DW - QW);
            divisor_in = DIVISOR_W'(MS_PER_S);
            cnt_in     = CNT_W'(QW);
            state_in   = S_DIV_Q;
         end
         S_DIV_Q: begin
            rem_in = div_rem_step;
            dq_in  = div_dq_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_STEP;
            end
         end
         // commit steps and position once the output register is free
         S_STEP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               remainder_in        = rest_adj[REM_W-1:0];
               position_in         = position_ff + POS_W'(steps);
               rsp_step_count_in   = steps;
               rsp_speed_now_in    = speed_ff;
               rsp_position_now_in = position_ff + POS_W'(steps);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_CAP: begin
               speed_cap_in = csr_write_data[SPEED_CAP_W-1:0];
            end
            CSR_ACCEL_RATE: begin
               accel_in = csr_write_data[ACCEL_W-1:0];
               state_in = S_INC_LOAD;
            end
            default: begin
            end
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INC_LOAD;
         rsp_valid_ff <= 1'b0;
         speed_cap_ff <= SPEED_CAP_W'(SPEED_CAP_RESET);
         accel_ff     <= ACCEL_W'(ACCEL_RATE_RESET);
         speed_ff     <= '0;
         position_ff  <= '0;
         remainder_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_cap_ff <= speed_cap_in;
         accel_ff     <= accel_in;
         speed_ff     <= speed_in;
         position_ff  <= position_in;
         remainder_ff <= remainder_in;
      end
      rsp_step_count_ff   <= rsp_step_count_in;
      rsp_speed_now_ff    <= rsp_speed_now_in;
      rsp_position_now_ff <= rsp_position_now_in;
      inc_ff              <= inc_in;
      inc_p_ff            <= inc_p_in;
      action_ff           <= action_in;
      tgt_speed_ff        <= tgt_speed_in;
      tgt_pos_ff          <= tgt_pos_in;
      ad_ff               <= ad_in;
      slow_ff             <= slow_in;
      stop_eq_ff          <= stop_eq_in;
      stop_lt_ff          <= stop_lt_in;
      snap_ff             <= snap_in;
      rem_ff              <= rem_in;
      dq_ff               <= dq_in;
      divisor_ff          <= divisor_in;
      cnt_ff              <= cnt_in;
   end

   // Ports
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_count   = rsp_step_count_ff;
   assign rsp_speed_now    = rsp_speed_now_ff;
   assign rsp_position_now = rsp_position_now_ff;

   // -----------------------------------------------------------------------
   // Checks

   // the divider never runs against a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_INC || state_ff == S_DIV_STOP || state_ff == S_DIV_Q)
      |-> divisor_ff != '0)
      else $error("divider running with zero divisor");

   // a waiting item shows the position the block holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_position_now_ff == position_ff)
      else $error("reported position differs from held position");

   // remainder stays strictly inside one step
   assert property (@(posedge clock) disable iff (reset)
      remainder_ff != REM_MIN)
      else $error("step remainder out of range");

   // an accepted item starts the path of its command kind
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !csr_write_enable)
      |=> ((state_ff == S_SQUARE) == ($past(req_action) == ACTION_POSITION)))
      else $error("item started on the wrong command path");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import ssrc_pkg::*;

   localparam int     INTERVAL_MS = UPDATE_INTERVAL_DEFAULT;
   localparam longint FRAC_ONE    = longint'(1) << FRAC_W;
   localparam int     SETTLE_CYC  = 60;   // longest item latency plus margin
   localparam int     LONG_HOLD   = 400;  // receiver hold-off, cycles
   localparam int     PHASE_ITEMS = 250;

   typedef struct packed {
      action_type                action;
      logic signed [SPEED_W-1:0] tspeed;
      logic signed [POS_W-1:0]   tpos;
   } ramp_cmd_type;

   typedef struct packed {
      logic signed [STEP_W-1:0]  steps;
      logic signed [SPEED_W-1:0] speed;
      logic signed [POS_W-1:0]   pos;
   } motion_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   action_type                req_action = ACTION_SPEED;
   logic signed [SPEED_W-1:0] req_target_speed = '0;
   logic signed [POS_W-1:0]   req_target_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [STEP_W-1:0]  rsp_step_count;
   logic signed [SPEED_W-1:0] rsp_speed_now;
   logic signed [POS_W-1:0]   rsp_position_now;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index = CSR_SPEED_CAP;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   // Pending items and expected motion results
   ramp_cmd_type cmd_queue[$];
   motion_type   pending_motion[$];

   // Predictor state and register copies
   int                     mdl_speed;
   int                     mdl_rem;
   logic [POS_W-1:0]       mdl_pos;
   logic [SPEED_CAP_W-1:0] mdl_speed_cap;
   logic [ACCEL_W-1:0]     mdl_accel;

   logic req_took = 1'b0;
   int   err_cnt = 0;
   int   rsp_cnt = 0;
   int   n_speed_cmd = 0;
   int   n_pos_cmd = 0;
   int   n_settings = 0;

   stepper_speed_ramp_controller u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_target_speed    (req_target_speed),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_step_count      (rsp_step_count),
      .rsp_speed_now       (rsp_speed_now),
      .rsp_position_now    (rsp_position_now),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("tb: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_cnt++;
      if (err_cnt <= 100)
         $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, rsp_cnt);
   endtask

   // One update interval: ramp the speed, then turn it into whole steps
   task automatic advance_motion(input ramp_cmd_type c, output motion_type m);
      longint spd, p, inc, lim, t, tgt, stop, stop_dist, mag, d, a;
      longint q, whole, frac, rest, carry, steps;
      begin
         spd = mdl_speed;
         p   = $signed(mdl_pos);
         inc = (longint'(mdl_accel) * (1 << Q8_SHIFT) * INTERVAL_MS) / MS_PER_S;
         if (c.action == ACTION_SPEED) begin
            lim = longint'(mdl_speed_cap) << Q8_SHIFT;
            t   = $signed(c.tspeed);
            if (t > lim) t = lim;
            if (t < -lim) t = -lim;
            if (spd < t) begin
               spd += inc;
               if (spd > t) spd = t;
            end else if (spd > t) begin
               spd -= inc;
               if (spd < t) spd = t;
            end
         end else begin
            tgt       = $signed(c.tpos);
            mag       = (spd < 0) ? -spd : spd;
            a         = (mdl_accel == 0) ? 1 : longint'(mdl_accel);
            stop_dist = (mag * mag) / (a << STOP_SHIFT);
            stop      = (spd >= 0) ? p + stop_dist : p - stop_dist;
            if (stop != tgt) begin
               d = tgt - p;
               if (d < 0) d = -d;
               // near the goal and slow: stop dead
               if (mag < inc && d * 256 < inc * INTERVAL_MS)
                  spd = 0;
               else if (stop < tgt)
                  spd += inc;
               else
                  spd -= inc;
            end
         end
         if (spd > SPEED_LIMIT) spd = SPEED_LIMIT;
         if (spd < -SPEED_LIMIT) spd = -SPEED_LIMIT;

         // Q16 step amount, remainder carried and truncated toward zero
         q     = (spd * INTERVAL_MS * 256) / MS_PER_S;
         whole = q / FRAC_ONE;
         frac  = q - whole * FRAC_ONE;
         rest  = longint'(mdl_rem) + frac;
         carry = rest / FRAC_ONE;
         rest  = rest - carry * FRAC_ONE;
         steps = whole + carry;
         if (steps > STEP_LIMIT) steps = STEP_LIMIT;
         if (steps < -STEP_LIMIT) steps = -STEP_LIMIT;

         mdl_speed = int'(spd);
         mdl_rem   = int'(rest);
         mdl_pos   = mdl_pos + steps[POS_W-1:0];
         m.steps   = steps[STEP_W-1:0];
         m.speed   = spd[SPEED_W-1:0];
         m.pos     = mdl_pos;
      end
   endtask

   // Monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      motion_type m;
      motion_type got;
      ramp_cmd_type c;
      if (reset) begin
         mdl_speed     = 0;
         mdl_rem       = 0;
         mdl_pos       = '0;
         mdl_speed_cap = SPEED_CAP_W'(SPEED_CAP_RESET);
         mdl_accel     = ACCEL_W'(ACCEL_RATE_RESET);
         req_took     <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPEED_CAP:  mdl_speed_cap = csr_write_data[SPEED_CAP_W-1:0];
               CSR_ACCEL_RATE: mdl_accel = csr_write_data[ACCEL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_cnt++;
            got.steps = rsp_step_count;
            got.speed = rsp_speed_now;
            got.pos   = rsp_position_now;
            if (pending_motion.size() == 0) begin
               report_mismatch("result with nothing expected, speed", got.speed, 0);
            end else begin
               m = pending_motion.pop_front();
               if (got.steps !== m.steps)
                  report_mismatch("step_count", got.steps, m.steps);
               if (got.speed !== m.speed)
                  report_mismatch("speed_now", got.speed, m.speed);
               if (got.pos !== m.pos)
                  report_mismatch("position_now", got.pos, m.pos);
            end
         end
         if (req_valid && !req_stall) begin
            c.action = req_action;
            c.tspeed = req_target_speed;
            c.tpos   = req_target_position;
            if (c.action == ACTION_SPEED) n_speed_cmd++;
            else n_pos_cmd++;
            advance_motion(c, m);
            pending_motion.push_back(m);
         end
      end
   end

   // Driver: bursts of items with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin
      ramp_cmd_type c;
      int unsigned r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            req_valid           <= 1'b1;
            req_action          <= c.action;
            req_target_speed    <= c.tspeed;
            req_target_position <= c.tpos;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               r = $urandom_range(0, 9);
               if (r < 4 || r == 9) gap_left = 0;
               else if (r < 8) gap_left = $urandom_range(1, 8);
               else gap_left = $urandom_range(9, 60);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: changing duty pattern, plus two long hold-offs
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   int unsigned pat_left = 0;
   int unsigned pat_period = 1;
   int unsigned pat_duty = 0;
   int unsigned pat_phase = 0;

   always @(negedge clock) begin
      if (holds_done < 2 && cmd_queue.size() > 100 && rsp_cnt >= 300 * (holds_done + 1)) begin
         hold_left = LONG_HOLD;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_left == 0) begin
            pat_left   = $urandom_range(50, 300);
            pat_period = $urandom_range(1, 12);
            pat_duty   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, pat_period - 1);
            pat_phase  = 0;
         end
         pat_left--;
         rsp_stall <= (pat_phase < pat_duty);
         pat_phase = (pat_phase + 1 >= pat_period) ? 0 : pat_phase + 1;
      end
   end

   task automatic queue_cmd(input action_type act, input int tspd, input longint tpos);
      ramp_cmd_type c;
      c.action = act;
      c.tspeed = tspd[SPEED_W-1:0];
      c.tpos   = tpos[POS_W-1:0];
      cmd_queue.push_back(c);
   endtask

   // Wait until every item has gone through and the block has settled
   task automatic drain_block();
      while (cmd_queue.size() != 0 || req_valid || pending_motion.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_regs(input int unsigned max_spd, input int unsigned accel);
      drain_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SPEED_CAP;
      csr_write_data   <= CSR_DATA_W'(max_spd);
      @(negedge clock);
      csr_index        <= CSR_ACCEL_RATE;
      csr_write_data   <= CSR_DATA_W'(accel);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      n_settings++;
   endtask

   function automatic int rand_speed_field();
      return int'($urandom_range(0, 2 * SPEED_LIMIT)) - SPEED_LIMIT;
   endfunction

   // Mostly runs of one command towards one goal, some noise in between
   task automatic queue_random_phase(input int n);
      int unsigned kind, len, k;
      longint base, off, lim;
      int tspd;
      begin
         base = $signed(mdl_pos);
         k = 0;
         while (k < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               case ($urandom_range(0, 3))
                  0: off = longint'($urandom_range(0, 128)) - 64;
                  1: off = longint'($urandom_range(0, 8000)) - 4000;
                  2: off = longint'($urandom_range(0, 400000)) - 200000;
                  default: off = longint'($signed($urandom())) - base;
               endcase
               len = $urandom_range(8, 40);
               repeat (len) queue_cmd(ACTION_POSITION, rand_speed_field(), base + off);
            end else if (kind < 7) begin
               lim = longint'(mdl_speed_cap) * 256 + 2000;
               if (lim > SPEED_LIMIT) lim = SPEED_LIMIT;
               case ($urandom_range(0, 4))
                  0: tspd = $urandom_range(0, 1) ? SPEED_LIMIT : -SPEED_LIMIT;
                  1: tspd = 0;
                  default: tspd = int'($urandom_range(0, 32'(2 * lim))) - int'(lim);
               endcase
               len = $urandom_range(4, 30);
               repeat (len) queue_cmd(ACTION_SPEED, tspd, $signed($urandom()));
            end else begin
               len = $urandom_range(1, 5);
               repeat (len)
                  queue_cmd(action_type'($urandom_range(0, 1)), rand_speed_field(),
                            $signed($urandom()));
            end
            k += len;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: rest on target, snap near goal, full-range goals and speeds
      queue_cmd(ACTION_POSITION, 0, 0);
      queue_cmd(ACTION_POSITION, 0, 1);
      queue_cmd(ACTION_POSITION, SPEED_LIMIT, 2147483647);
      queue_cmd(ACTION_POSITION, -SPEED_LIMIT, 2147483647);
      queue_cmd(ACTION_POSITION, 0, 2147483647);
      queue_cmd(ACTION_POSITION, 0, -2147483648);
      queue_cmd(ACTION_POSITION, 0, -2147483648);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, -1);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, 0);
      queue_cmd(ACTION_SPEED, -SPEED_LIMIT, 0);
      queue_cmd(ACTION_SPEED, 0, 0);
      queue_cmd(ACTION_SPEED, 0, 0);

      // Largest registers: clamp, saturation of the speed
      set_regs(4095, 65535);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, 0);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, 0);
      queue_cmd(ACTION_POSITION, 0, 2147483647);
      queue_cmd(ACTION_SPEED, -SPEED_LIMIT, 0);
      queue_cmd(ACTION_SPEED, -SPEED_LIMIT, 0);
      queue_cmd(ACTION_POSITION, 0, -2147483648);

      // Zero acceleration and zero speed limit
      set_regs(0, 0);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, 0);
      queue_cmd(ACTION_POSITION, 0, 2147483647);
      queue_cmd(ACTION_POSITION, 0, 0);
      set_regs(0, 1);
      queue_cmd(ACTION_SPEED, SPEED_LIMIT, 0);
      queue_cmd(ACTION_SPEED, 0, 0);

      // Random phases over a spread of settings
      set_regs(SPEED_CAP_RESET, ACCEL_RATE_RESET);
      queue_random_phase(PHASE_ITEMS);
      set_regs(4095, 65535);
      queue_random_phase(PHASE_ITEMS);
      set_regs(4095, 1);
      queue_random_phase(PHASE_ITEMS);
      set_regs(1, 65535);
      queue_random_phase(PHASE_ITEMS);
      set_regs($urandom_range(0, 4095), $urandom_range(1, 2000));
      queue_random_phase(PHASE_ITEMS);
      set_regs($urandom_range(0, 4095), $urandom_range(1, 65535));
      queue_random_phase(PHASE_ITEMS);
      set_regs($urandom_range(0, 4095), $urandom_range(1, 300));
      queue_random_phase(PHASE_ITEMS);
      set_regs(0, 1);
      queue_random_phase(PHASE_ITEMS);

      drain_block();
      if (pending_motion.size() != 0)
         report_mismatch("results left outstanding", pending_motion.size(), 0);

      $display("summary: %0d speed and %0d position items under %0d register settings",
               n_speed_cmd, n_pos_cmd, n_settings + 1);
      $display("summary: %0d results checked, %0d long receiver hold-offs, %0d mismatches",
               rsp_cnt, holds_done, err_cnt);
      if (err_cnt == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ssrc_pkg.sv
rtl/stepper_speed_ramp_controller.sv
bench/tb.sv
